/* sv/ial_pkg.sv */
`timescale 1ns / 1ps

package ial_pkg;

  typedef enum logic [4:0] {
    FN_ADD  = 5'd0,
    FN_OR   = 5'd1,
    FN_ADC  = 5'd2,
    FN_SBB  = 5'd3,
    FN_AND  = 5'd4,
    FN_SUB  = 5'd5,
    FN_XOR  = 5'd6,
    FN_CMP  = 5'd7,
    FN_TEST = 5'd8,
    FN_SHL  = 5'd9,
    FN_SHR  = 5'd10,
    FN_SAR  = 5'd11,
    FN_ROL  = 5'd12,
    FN_ROR  = 5'd13,
    FN_RCL  = 5'd14,
    FN_RCR  = 5'd15,
    FN_NOT  = 5'd16,
    FN_NEG  = 5'd17,
    FN_INC  = 5'd18,
    FN_DEC  = 5'd19,
    FN_MUL  = 5'd20,
    FN_IMUL = 5'd21
  } func_t;

  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;

  localparam logic [4:0] COUNT_MASK = 5'h1F;

  localparam int FL_CF = 0;
  localparam int FL_PF = 1;
  localparam int FL_AF = 2;
  localparam int FL_ZF = 3;
  localparam int FL_SF = 4;
  localparam int FL_OF = 5;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ial_cmd_t;

endpackage

/* sv/ial_ctrl.sv */
`timescale 1ns / 1ps

module ial_ctrl import ial_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ial_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ial_dp.sv */
`timescale 1ns / 1ps

module ial_dp import ial_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ial_cmd_t    cmd,
  input  logic [4:0]  func,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [1:0]  width_code,
  output logic [31:0] result_low,
  output logic [31:0] result_high,
  output logic [5:0]  flags_out
);

  function automatic logic [31:0] mask_of(input logic [1:0] wc);
    case (wc)
      WC_8:    return 32'h0000_00FF;
      WC_16:   return 32'h0000_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic msb_of(input logic [31:0] v, input logic [1:0] wc);
    case (wc)
      WC_8:    return v[7];
      WC_16:   return v[15];
      default: return v[31];
    endcase
  endfunction

  function automatic logic nxt_of(input logic [31:0] v, input logic [1:0] wc);
    case (wc)
      WC_8:    return v[6];
      WC_16:   return v[14];
      default: return v[30];
    endcase
  endfunction

  // capture stage
  logic [31:0]        m_in, a_in, b_in;
  logic               sx_a, sx_b;
  logic [32:0]        ea, eb;
  logic signed [65:0] prod_full;
  logic [4:0]         c_in, rc_in;

  logic [4:0]  func_r;
  logic [1:0]  wc_r;
  logic [31:0] a_r, b_r;
  logic [63:0] prod_r;
  logic [4:0]  rcnt_r;

  always_comb begin
    m_in = mask_of(width_code);
    a_in = operand_a & m_in;
    b_in = operand_b & m_in;
    sx_a = (func == FN_IMUL) && msb_of(a_in, width_code);
    sx_b = (func == FN_IMUL) && msb_of(b_in, width_code);
    ea   = ({33{sx_a}} & ~{1'b0, m_in}) | {1'b0, a_in};
    eb   = ({33{sx_b}} & ~{1'b0, m_in}) | {1'b0, b_in};
    prod_full = $signed(ea) * $signed(eb);
    c_in = b_in[4:0] & COUNT_MASK;
    case (width_code)
      WC_8: begin
        if (c_in >= 5'd27)      rc_in = c_in - 5'd27;
        else if (c_in >= 5'd18) rc_in = c_in - 5'd18;
        else if (c_in >= 5'd9)  rc_in = c_in - 5'd9;
        else                    rc_in = c_in;
      end
      WC_16: begin
        if (c_in >= 5'd17) rc_in = c_in - 5'd17;
        else               rc_in = c_in;
      end
      default: rc_in = c_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      wc_r   <= width_code;
      a_r    <= a_in;
      b_r    <= b_in;
      prod_r <= prod_full[63:0];
      rcnt_r <= rc_in;
    end
  end

  // execute stage
  logic [31:0] m, lo, hi, x, y, ar;
  logic [5:0]  fl, flags_r;
  logic [32:0] sum, dif;
  logic        cin, sub, ci, acf, aof, aaf;
  logic        cf, of;
  logic [4:0]  c;
  logic [63:0] shl;
  logic [32:0] shr;
  logic [31:0] sa;
  logic [32:0] sar;
  logic [63:0] rot;
  logic [65:0] rc;
  logic [32:0] rr;
  logic [4:0]  k;

  always_comb begin
    m   = mask_of(wc_r);
    cin = flags_r[FL_CF];
    c   = b_r[4:0] & COUNT_MASK;

    x   = a_r;
    y   = b_r;
    ci  = 1'b0;
    sub = 1'b0;
    case (func_r)
      FN_ADC: ci = cin;
      FN_SBB: begin
        sub = 1'b1;
        ci  = cin;
      end
      FN_SUB, FN_CMP: sub = 1'b1;
      FN_NEG: begin
        sub = 1'b1;
        x   = 32'd0;
        y   = a_r;
      end
      FN_INC: y = 32'd1;
      FN_DEC: begin
        sub = 1'b1;
        y   = 32'd1;
      end
      default: sub = 1'b0;
    endcase
    sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
    dif = {1'b0, x} - {1'b0, y} - {32'd0, ci};
    ar  = (sub ? dif[31:0] : sum[31:0]) & m;
    case (wc_r)
      WC_8:    acf = sub ? dif[32] : sum[8];
      WC_16:   acf = sub ? dif[32] : sum[16];
      default: acf = sub ? dif[32] : sum[32];
    endcase
    aaf = x[4] ^ y[4] ^ ar[4];
    aof = sub ? msb_of((x ^ y) & (x ^ ar), wc_r) : msb_of((x ^ ar) & (y ^ ar), wc_r);

    shl = {32'd0, a_r} << c;
    shr = {a_r, 1'b0} >> c;
    sa  = a_r | ({32{msb_of(a_r, wc_r)}} & ~m);
    sar = $signed({sa, 1'b0}) >>> c;

    case (wc_r)
      WC_8:    k = {2'b00, c[2:0]};
      WC_16:   k = {1'b0, c[3:0]};
      default: k = c;
    endcase
    case (wc_r)
      WC_8:    rot = {48'd0, a_r[7:0], a_r[7:0]};
      WC_16:   rot = {32'd0, a_r[15:0], a_r[15:0]};
      default: rot = {a_r, a_r};
    endcase
    if (func_r == FN_ROL) rot = rot << k;
    else                  rot = rot >> k;

    case (wc_r)
      WC_8:    rc = {48'd0, cin, a_r[7:0], cin, a_r[7:0]};
      WC_16:   rc = {32'd0, cin, a_r[15:0], cin, a_r[15:0]};
      default: rc = {cin, a_r, cin, a_r};
    endcase
    if (func_r == FN_RCL) rc = rc << rcnt_r;
    else                  rc = rc >> rcnt_r;
    case (wc_r)
      WC_8:    rr = (func_r == FN_RCL) ? {24'd0, rc[17:9]}  : {24'd0, rc[8:0]};
      WC_16:   rr = (func_r == FN_RCL) ? {16'd0, rc[33:17]} : {16'd0, rc[16:0]};
      default: rr = (func_r == FN_RCL) ? rc[65:33]          : rc[32:0];
    endcase

    lo = 32'd0;
    hi = 32'd0;
    fl = flags_r;
    cf = 1'b0;
    of = 1'b0;
    case (func_r)
      FN_ADD, FN_ADC, FN_SBB, FN_SUB, FN_CMP, FN_NEG, FN_INC, FN_DEC: begin
        lo = ar;
        cf = (func_r == FN_INC || func_r == FN_DEC) ? cin : acf;
        fl = {aof, msb_of(lo, wc_r), lo == 32'd0, aaf, ~^lo[7:0], cf};
      end
      FN_OR, FN_AND, FN_TEST, FN_XOR: begin
        if (func_r == FN_OR)       lo = a_r | b_r;
        else if (func_r == FN_XOR) lo = a_r ^ b_r;
        else                       lo = a_r & b_r;
        fl = {1'b0, msb_of(lo, wc_r), lo == 32'd0, 1'b0, ~^lo[7:0], 1'b0};
      end
      FN_SHL, FN_SHR, FN_SAR: begin
        if (c == 5'd0) begin
          lo = a_r;
        end else begin
          if (func_r == FN_SHL) begin
            lo = shl[31:0] & m;
            case (wc_r)
              WC_8:    cf = shl[8];
              WC_16:   cf = shl[16];
              default: cf = shl[32];
            endcase
            of = msb_of(lo, wc_r) ^ cf;
          end else if (func_r == FN_SHR) begin
            lo = shr[32:1];
            cf = shr[0];
            of = msb_of(a_r, wc_r);
          end else begin
            lo = sar[32:1] & m;
            cf = sar[0];
            of = 1'b0;
          end
          fl = {of, msb_of(lo, wc_r), lo == 32'd0, 1'b0, ~^lo[7:0], cf};
        end
      end
      FN_ROL, FN_ROR: begin
        if (c == 5'd0) begin
          lo = a_r;
        end else begin
          if (func_r == FN_ROL) begin
            case (wc_r)
              WC_8:    lo = {24'd0, rot[15:8]};
              WC_16:   lo = {16'd0, rot[31:16]};
              default: lo = rot[63:32];
            endcase
            cf = lo[0];
            of = msb_of(lo, wc_r) ^ cf;
          end else begin
            lo = rot[31:0] & m;
            cf = msb_of(lo, wc_r);
            of = cf ^ nxt_of(lo, wc_r);
          end
          fl[FL_CF] = cf;
          fl[FL_OF] = of;
        end
      end
      FN_RCL, FN_RCR: begin
        if (c == 5'd0) begin
          lo = a_r;
        end else begin
          lo = rr[31:0] & m;
          case (wc_r)
            WC_8:    cf = rr[8];
            WC_16:   cf = rr[16];
            default: cf = rr[32];
          endcase
          if (func_r == FN_RCL) of = msb_of(lo, wc_r) ^ cf;
          else                  of = msb_of(lo, wc_r) ^ nxt_of(lo, wc_r);
          fl[FL_CF] = cf;
          fl[FL_OF] = of;
        end
      end
      FN_NOT: lo = ~a_r & m;
      FN_MUL, FN_IMUL: begin
        lo = prod_r[31:0] & m;
        case (wc_r)
          WC_8:    hi = {24'd0, prod_r[15:8]};
          WC_16:   hi = {16'd0, prod_r[31:16]};
          default: hi = prod_r[63:32];
        endcase
        if (func_r == FN_MUL) cf = hi != 32'd0;
        else                  cf = hi != ({32{msb_of(lo, wc_r)}} & m);
        fl[FL_CF] = cf;
        fl[FL_OF] = cf;
      end
      default: lo = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 6'd0;
    end else if (cmd.commit) begin
      flags_r <= fl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_low  <= lo;
      result_high <= hi;
    end
  end

  assign flags_out = flags_r;

endmodule

/* sv/integer_alu_with_flags.sv */
`timescale 1ns / 1ps
// channel | ports                                                   | beat taken when
// input   | in_valid in_stall in_func in_operand_a in_operand_b     | in_valid && !in_stall
//         | in_width_code                                           |
// output  | out_valid out_stall out_result_low out_result_high      | out_valid && !out_stall
//         | out_flags_out                                           |
// One beat at a time: capture with the 33x33 multiply and rotate-count
// reduction, then execute and load the output register.
// Flags chain from one beat into the next execute cycle.
// Synchronous reset clears the flags and the controller.
// A stalled result holds the block in execute until the output register frees.

module integer_alu_with_flags import ial_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_func,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [1:0]  in_width_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic [5:0]  out_flags_out
);

  ial_cmd_t cmd;

  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ial_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .func        (in_func),
    .operand_a   (in_operand_a),
    .operand_b   (in_operand_b),
    .width_code  (in_width_code),
    .result_low  (out_result_low),
    .result_high (out_result_high),
    .flags_out   (out_flags_out)
  );

endmodule

/* sv/ial_chk.sv */
`timescale 1ns / 1ps

module ial_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_low,
  input logic [5:0]  out_flags_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_low) && $stable(out_flags_out))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an executing beat");

endmodule

bind integer_alu_with_flags ial_chk u_ial_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_result_low (out_result_low),
  .out_flags_out  (out_flags_out)
);

/* test/integer_alu_with_flags_tb.sv */
`timescale 1ns / 1ps

module integer_alu_with_flags_tb;
  import ial_pkg::*;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [5:0]  flags;
  } alu_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_func;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [1:0]  in_width_code;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_low;
  logic [31:0] out_result_high;
  logic [5:0]  out_flags_out;

  alu_res_t   expected_q[$];
  logic [5:0] model_flags;
  int         error_count;
  int         send_idle_pct;
  int         recv_stall_pct;

  integer_alu_with_flags i_dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [5:0] szp_flags(logic [31:0] r, int nb);
    logic [5:0] f;
    f = '0;
    f[FL_PF] = ~^r[7:0];
    f[FL_ZF] = (r == 0);
    f[FL_SF] = r[nb-1];
    return f;
  endfunction

  function automatic alu_res_t alu_predict(logic [4:0] fn, logic [31:0] ain,
                                           logic [31:0] bin, logic [1:0] wc);
    alu_res_t   res;
    int         nb;
    logic [31:0] m, a, b, lo, hi;
    logic [5:0] f;
    logic [63:0] full, sum;
    logic        cin, cf, of, o, sgn;
    int          cnt;
    longint      sa, sb, sp, slo;

    nb = (wc == WC_8) ? 8 : (wc == WC_16) ? 16 : 32;
    m = (nb == 32) ? 32'hFFFF_FFFF : ((32'd1 << nb) - 1);
    a = ain & m;
    b = bin & m;
    f = model_flags;
    cin = f[FL_CF];
    lo = '0;
    hi = '0;
    cnt = b[4:0] & COUNT_MASK;
    case (fn)
      FN_ADD, FN_ADC, FN_INC: begin
        if (fn == FN_ADD) cin = 1'b0;
        if (fn == FN_INC) begin
          b = 32'd1;
          cin = 1'b0;
        end
        sum = 64'(a) + 64'(b) + 64'(cin);
        lo = sum[31:0] & m;
        f = szp_flags(lo, nb);
        f[FL_CF] = sum > 64'(m);
        f[FL_AF] = a[4] ^ b[4] ^ lo[4];
        f[FL_OF] = ((a ^ lo) & (b ^ lo)) >> (nb - 1);
        if (fn == FN_INC) f[FL_CF] = model_flags[FL_CF];
      end
      FN_SUB, FN_CMP, FN_SBB, FN_NEG, FN_DEC: begin
        if (fn == FN_NEG) begin
          b = a;
          a = 32'd0;
        end
        if (fn == FN_DEC) b = 32'd1;
        if (fn != FN_SBB) cin = 1'b0;
        lo = (a - b - 32'(cin)) & m;
        f = szp_flags(lo, nb);
        f[FL_CF] = 64'(a) < 64'(b) + 64'(cin);
        f[FL_AF] = a[4] ^ b[4] ^ lo[4];
        f[FL_OF] = ((a ^ b) & (a ^ lo)) >> (nb - 1);
        if (fn == FN_DEC) f[FL_CF] = model_flags[FL_CF];
      end
      FN_OR: begin
        lo = a | b;
        f = szp_flags(lo, nb);
      end
      FN_AND, FN_TEST: begin
        lo = a & b;
        f = szp_flags(lo, nb);
      end
      FN_XOR: begin
        lo = a ^ b;
        f = szp_flags(lo, nb);
      end
      FN_SHL, FN_SHR, FN_SAR: begin
        lo = a;
        if (cnt != 0) begin
          sgn = a[nb-1];
          if (fn == FN_SHL) begin
            lo = (cnt >= nb) ? 0 : ((a << cnt) & m);
            cf = (cnt > nb) ? 1'b0 : a[nb-cnt];
            of = lo[nb-1] ^ cf;
          end else if (fn == FN_SHR) begin
            lo = (cnt >= nb) ? 0 : (a >> cnt);
            cf = (cnt > nb) ? 1'b0 : a[cnt-1];
            of = sgn;
          end else begin
            if (cnt >= nb) begin
              lo = sgn ? m : 0;
              cf = sgn;
            end else begin
              lo = a >> cnt;
              if (sgn) lo = lo | ((m << (nb - cnt)) & m);
              cf = a[cnt-1];
            end
            of = 1'b0;
          end
          f = szp_flags(lo, nb);
          f[FL_CF] = cf;
          f[FL_OF] = of;
        end
      end
      FN_ROL, FN_ROR: begin
        lo = a;
        if (cnt != 0) begin
          cnt = cnt & (nb - 1);
          if (cnt != 0) begin
            if (fn == FN_ROL) lo = ((a << cnt) | (a >> (nb - cnt))) & m;
            else lo = ((a >> cnt) | (a << (nb - cnt))) & m;
          end
          if (fn == FN_ROL) begin
            cf = lo[0];
            of = lo[nb-1] ^ cf;
          end else begin
            cf = lo[nb-1];
            of = cf ^ lo[nb-2];
          end
          f[FL_CF] = cf;
          f[FL_OF] = of;
        end
      end
      FN_RCL, FN_RCR: begin
        lo = a;
        if (cnt != 0) begin
          cnt = cnt % (nb + 1);
          cf = cin;
          for (int i = 0; i < cnt; i++) begin
            if (fn == FN_RCL) begin
              o = lo[nb-1];
              lo = ((lo << 1) | 32'(cf)) & m;
            end else begin
              o = lo[0];
              lo = (lo >> 1) | (32'(cf) << (nb - 1));
            end
            cf = o;
          end
          of = (fn == FN_RCL) ? (lo[nb-1] ^ cf) : (lo[nb-1] ^ lo[nb-2]);
          f[FL_CF] = cf;
          f[FL_OF] = of;
        end
      end
      FN_NOT: lo = ~a & m;
      FN_MUL: begin
        full = 64'(a) * 64'(b);
        lo = full[31:0] & m;
        hi = (full >> nb) & m;
        f[FL_CF] = hi != 0;
        f[FL_OF] = hi != 0;
      end
      FN_IMUL: begin
        sa = a[nb-1] ? longint'(a) - (64'sd1 <<< nb) : longint'(a);
        sb = b[nb-1] ? longint'(b) - (64'sd1 <<< nb) : longint'(b);
        sp = sa * sb;
        lo = sp[31:0] & m;
        hi = (sp >>> nb) & m;
        slo = lo[nb-1] ? longint'(lo) - (64'sd1 <<< nb) : longint'(lo);
        f[FL_CF] = slo != sp;
        f[FL_OF] = slo != sp;
      end
      default: ;
    endcase
    model_flags = f;
    res.lo = lo;
    res.hi = hi;
    res.flags = f;
    return res;
  endfunction

  task automatic send_op(logic [4:0] fn, logic [31:0] a, logic [31:0] b, logic [1:0] wc);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    in_width_code <= wc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(alu_predict(fn, a, b, wc));
    @(negedge clk);
  endtask

  task automatic send_random(int n, bit favor_count);
    logic [31:0] b;
    logic [4:0]  fn;
    for (int i = 0; i < n; i++) begin
      fn = 5'($urandom_range(31, 0));
      if ($urandom_range(9, 0) != 0) fn = 5'($urandom_range(21, 0));
      b = $urandom;
      if (favor_count || $urandom_range(3, 0) == 0) b = $urandom_range(40, 0);
      case ($urandom_range(5, 0))
        0: send_op(fn, 32'hFFFF_FFFF, b, 2'($urandom_range(3, 0)));
        1: send_op(fn, {1'($urandom_range(1, 0)), 31'h0}, b, 2'($urandom_range(3, 0)));
        default: send_op(fn, $urandom, b, 2'($urandom_range(3, 0)));
      endcase
    end
  endtask

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_result_low !== exp_r.lo) begin
          $error("result_low exp %h got %h", exp_r.lo, out_result_low);
          error_count++;
        end
        if (out_result_high !== exp_r.hi) begin
          $error("result_high exp %h got %h", exp_r.hi, out_result_high);
          error_count++;
        end
        if (out_flags_out !== exp_r.flags) begin
          $error("flags_out exp %h got %h", exp_r.flags, out_flags_out);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic test_extremes();
    logic [1:0] wc;
    for (int w = 0; w < 3; w++) begin
      wc = 2'(w);
      send_op(FN_ADD, 32'hFFFF_FFFF, 32'h1, wc);
      send_op(FN_ADC, 32'h7FFF_FFFF, 32'h0, wc);
      send_op(FN_SBB, 32'h0, 32'h0, wc);
      send_op(FN_IMUL, 32'h8000_0000, 32'hFFFF_FFFF, wc);
      send_op(FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, wc);
      send_op(FN_SAR, 32'h8000_0080, 32'd31, wc);
    end
    send_op(FN_SHL, 32'h1, 32'd0, WC_8);
    send_op(FN_SHR, 32'h80, 32'd9, WC_8);
    send_op(FN_ROL, 32'h81, 32'd16, WC_16);
    send_op(FN_RCR, 32'h1, 32'd17, WC_16);
    send_op(FN_NEG, 32'h0, 32'h0, 2'd3);
    send_op(5'd31, 32'h1234, 32'h5, WC_8);
  endtask

  task automatic test_every_op();
    for (int fn = 0; fn < 23; fn++)
      send_op(5'(fn), $urandom, $urandom_range(33, 1), 2'($urandom_range(2, 0)));
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(200, 1'b0);
    send_idle_pct = 65;
    send_random(200, 1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    send_random(200, 1'b0);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_random(250, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_width_code = '0;
    out_stall = 1'b0;
    model_flags = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_every_op();
    test_random_phases();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* integer_alu_with_flags.f */
sv/ial_pkg.sv
sv/ial_ctrl.sv
sv/ial_dp.sv
sv/integer_alu_with_flags.sv
sv/ial_chk.sv
test/integer_alu_with_flags_tb.sv
